>>> hdl/assert_macros.svh
// Assertion macros shared by the semiprime classifier modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("semiprime classifier assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("semiprime classifier assertion failed");

`endif

>>> hdl/spc_pkg.sv
// Shared constants, types and interface structs of the semiprime classifier.
// No dependencies; every module file imports it.
package spc_pkg;

    localparam int NUMBER_WIDTH = 16;
    // Trial divisor: holds every value up to one past the square root.
    localparam int ROOT_WIDTH   = (NUMBER_WIDTH + 1) / 2 + 1;
    // Square of the trial divisor, which may pass the largest number.
    localparam int SQUARE_WIDTH = NUMBER_WIDTH + 1;
    localparam int COUNT_WIDTH  = $clog2(NUMBER_WIDTH + 1);

    typedef enum logic [1:0] {
        VERDICT_PRIME   = 2'd0,
        VERDICT_SEMI    = 2'd1,
        VERDICT_NEITHER = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_N,
        ST_DIV_STRIP,
        ST_DIV_REST,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic                    start;
        logic [NUMBER_WIDTH-1:0] dividend;
        logic [NUMBER_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [NUMBER_WIDTH-1:0] quotient;
        logic [NUMBER_WIDTH-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        verdict_t                verdict;
        logic [NUMBER_WIDTH-1:0] factor_small;
        logic [NUMBER_WIDTH-1:0] factor_large;
    } result_t;

endpackage

>>> hdl/spc_divider.sv
// Shared restoring divider: one quotient bit per cycle, quotient and remainder.
// Depends on spc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spc_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  spc_pkg::div_req_t req,
    output spc_pkg::div_rsp_t rsp
);
    import spc_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [COUNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [NUMBER_WIDTH-1:0] quo_reg, quo_next;
    logic [NUMBER_WIDTH-1:0] rem_reg, rem_next;
    logic [NUMBER_WIDTH-1:0] dvs_reg, dvs_next;
    logic [NUMBER_WIDTH:0]   partial;
    logic [NUMBER_WIDTH:0]   diff;
    logic                    fits;

    // The dividend shifts out of the top of quo_reg as quotient bits shift in.
    assign partial = {rem_reg, quo_reg[NUMBER_WIDTH-1]};
    assign diff    = partial - {1'b0, dvs_reg};
    assign fits    = ~diff[NUMBER_WIDTH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = COUNT_WIDTH'(NUMBER_WIDTH);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[NUMBER_WIDTH-1:0] : partial[NUMBER_WIDTH-1:0];
            quo_next = {quo_reg[NUMBER_WIDTH-2:0], fits};
            cnt_next = cnt_reg - COUNT_WIDTH'(1);
            if (cnt_reg == COUNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `SPC_ASSERT_IMP(a_no_restart, clk, rst_n, req.start, !busy_reg)
    `SPC_ASSERT_IMP(a_divisor_nonzero, clk, rst_n, req.start, req.divisor != '0)
    `SPC_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

>>> hdl/spc_sequencer.sv
// Trial-division sequencer: walks the divisors and drives the shared divider.
// Depends on spc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spc_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [spc_pkg::NUMBER_WIDTH-1:0]  number,
    input  logic                              slot_free,
    output logic                              busy,
    output logic                              res_valid,
    output spc_pkg::result_t                  res,
    output spc_pkg::div_req_t                 div_req,
    input  spc_pkg::div_rsp_t                 div_rsp
);
    import spc_pkg::*;

    seq_state_t              state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] n_reg, n_next;
    logic [ROOT_WIDTH-1:0]   m_reg, m_next;
    logic [SQUARE_WIDTH-1:0] sq_reg, sq_next;
    logic [ROOT_WIDTH-1:0]   p_reg, p_next;
    logic [NUMBER_WIDTH-1:0] q_reg, q_next;
    logic [NUMBER_WIDTH-1:0] rest_reg, rest_next;
    logic                    found_reg, found_next;
    logic                    psq_reg, psq_next;
    result_t                 res_reg, res_next;

    logic                    loop_end;
    logic                    rem_zero;
    logic                    too_small;
    logic                    is_square;
    logic [SQUARE_WIDTH-1:0] sq_step;

    // The loop ends once the divisor passes the root, or when the cofactor
    // has been reduced to one and no second prime can turn up.
    assign loop_end  = (sq_reg > {1'b0, n_reg}) ||
                       (found_reg && (rest_reg == NUMBER_WIDTH'(1)));
    assign rem_zero  = (div_rsp.remainder == '0);
    assign too_small = (number < NUMBER_WIDTH'(2));
    assign is_square = (sq_reg == {1'b0, n_reg});
    // (m + 1)^2 = m^2 + 2m + 1
    assign sq_step   = SQUARE_WIDTH'({m_reg, 1'b1});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = too_small ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (loop_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = found_reg ? ST_DIV_REST : ST_DIV_N;
                end
            end
            ST_DIV_N:
            begin
                if (div_rsp.done)
                begin
                    if (rem_zero)
                    begin
                        state_next = is_square ? ST_DONE : ST_DIV_STRIP;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DIV_STRIP:
            begin
                if (div_rsp.done)
                begin
                    state_next = rem_zero ? ST_DIV_STRIP : ST_CHECK;
                end
            end
            ST_DIV_REST:
            begin
                if (div_rsp.done)
                begin
                    state_next = rem_zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next     = n_reg;
        m_next     = m_reg;
        sq_next    = sq_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        rest_next  = rest_reg;
        found_next = found_reg;
        psq_next   = psq_reg;
        res_next   = res_reg;
        div_req    = '0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = number;
                    m_next     = ROOT_WIDTH'(2);
                    sq_next    = SQUARE_WIDTH'(4);
                    found_next = 1'b0;
                    psq_next   = 1'b0;
                    res_next   = '{verdict: VERDICT_NEITHER, factor_small: '0,
                                   factor_large: '0};
                end
            end
            ST_CHECK:
            begin
                if (loop_end)
                begin
                    if (!found_reg)
                    begin
                        res_next = '{verdict: VERDICT_PRIME, factor_small: '0,
                                     factor_large: '0};
                    end
                    else
                    begin
                        res_next = '{verdict: psq_reg ? VERDICT_NEITHER : VERDICT_SEMI,
                                     factor_small: NUMBER_WIDTH'(p_reg),
                                     factor_large: q_reg};
                    end
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = found_reg ? rest_reg : n_reg;
                    div_req.divisor  = NUMBER_WIDTH'(m_reg);
                end
            end
            ST_DIV_N:
            begin
                if (div_rsp.done)
                begin
                    if (rem_zero && is_square)
                    begin
                        res_next = '{verdict: VERDICT_SEMI,
                                     factor_small: NUMBER_WIDTH'(m_reg),
                                     factor_large: NUMBER_WIDTH'(m_reg)};
                    end
                    else if (rem_zero)
                    begin
                        p_next           = m_reg;
                        found_next       = 1'b1;
                        q_next           = div_rsp.quotient;
                        rest_next        = div_rsp.quotient;
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = NUMBER_WIDTH'(m_reg);
                    end
                    else
                    begin
                        m_next  = m_reg + ROOT_WIDTH'(1);
                        sq_next = sq_reg + sq_step;
                    end
                end
            end
            ST_DIV_STRIP:
            begin
                if (div_rsp.done)
                begin
                    if (rem_zero)
                    begin
                        // p divides n / p, so p squared divides n.
                        rest_next        = div_rsp.quotient;
                        psq_next         = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = NUMBER_WIDTH'(p_reg);
                    end
                    else
                    begin
                        m_next  = m_reg + ROOT_WIDTH'(1);
                        sq_next = sq_reg + sq_step;
                    end
                end
            end
            ST_DIV_REST:
            begin
                if (div_rsp.done)
                begin
                    if (rem_zero)
                    begin
                        res_next = '{verdict: VERDICT_NEITHER,
                                     factor_small: NUMBER_WIDTH'(p_reg),
                                     factor_large: NUMBER_WIDTH'(m_reg)};
                    end
                    else
                    begin
                        m_next  = m_reg + ROOT_WIDTH'(1);
                        sq_next = sq_reg + sq_step;
                    end
                end
            end
            ST_DONE:
            begin
                res_valid = slot_free;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        m_reg     <= m_next;
        sq_reg    <= sq_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        rest_reg  <= rest_next;
        found_reg <= found_next;
        psq_reg   <= psq_next;
        res_reg   <= res_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = res_reg;

    `SPC_ASSERT_IMP(a_done_in_div, clk, rst_n, div_rsp.done, (state_reg == ST_DIV_N) || (state_reg == ST_DIV_STRIP) || (state_reg == ST_DIV_REST))
    `SPC_ASSERT_NXT(a_emit_then_idle, clk, rst_n, res_valid, state_reg == ST_IDLE)

endmodule

>>> hdl/semiprime_classifier.sv
// Top level of the semiprime classifier: ports, result register, sequencer
// and shared divider. Depends on spc_pkg, spc_sequencer, spc_divider.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+-----------------------------------
//  input   | in        | in_valid/in_stall | number
//  output  | out       | out_valid/out_stall | verdict, factor_small, factor_large
//
// Each item takes one division per trial divisor, plus one more for every
// further division by the first prime factor found. The single bit-serial
// divider produces one quotient bit a cycle while a division runs and serves
// every trial in turn, so a new division starts only once the last is done.
// Reset is asynchronous and active low; it returns the sequencer to idle and
// empties the result register. No memory needs clearing.
// in_stall is high while an item is being worked on. A finished result waits
// in the sequencer until the output register frees, so a
// stalled output holds the classifier in its done state.
`include "assert_macros.svh"

module semiprime_classifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [spc_pkg::NUMBER_WIDTH-1:0] number,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       verdict,
    output logic [spc_pkg::NUMBER_WIDTH-1:0] factor_small,
    output logic [spc_pkg::NUMBER_WIDTH-1:0] factor_large
);
    import spc_pkg::*;

    div_req_t div_req;
    div_rsp_t div_rsp;
    result_t  res;
    logic     res_valid;
    logic     busy;
    logic     slot_free;
    logic     in_accept;

    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg, out_res_next;

    // The result register is free when empty or when its item leaves now.
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_accept = in_valid && !busy;
    assign in_stall  = busy;

    spc_sequencer u_sequencer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .number    (number),
        .slot_free (slot_free),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    spc_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = out_res_reg.verdict;
    assign factor_small = out_res_reg.factor_small;
    assign factor_large = out_res_reg.factor_large;

    // An accepted item must keep the input stalled until it is classified.
    `SPC_ASSERT_NXT(a_accept_then_busy, clk, rst_n, in_accept, in_stall)

endmodule
